/* src/fbc_pkg.sv */
package fbc_pkg;

    // field widths fixed by the item format
    localparam int COORD_BITS   = 32;
    localparam int FRAC_BITS    = 16;
    localparam int INDEX_BITS   = 3;
    localparam int VERDICT_BITS = 2;

    // plane table sizing
    localparam int PLANE_COUNT_DEF = 6;
    localparam int PLANE_COUNT_MAX = 8;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // box geometry
    localparam int AXES         = 3;
    localparam int CORNER_COUNT = 8;

    // datapath widths: exact products, exact three-term sums, scaled offset
    localparam int PROD_BITS = 2 * COORD_BITS;
    localparam int SUM_BITS  = PROD_BITS + 2;
    localparam int LIM_BITS  = COORD_BITS + FRAC_BITS;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [PROD_BITS-1:0]  prod_t;
    typedef logic signed [SUM_BITS-1:0]   sum_t;
    typedef logic signed [LIM_BITS-1:0]   lim_t;
    typedef logic [VERDICT_BITS-1:0]      verdict_t;

    // command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TEST = 1'b1;

    // verdict codes
    localparam verdict_t VERDICT_CULLED  = 2'd0;
    localparam verdict_t VERDICT_PARTIAL = 2'd1;
    localparam verdict_t VERDICT_VISIBLE = 2'd2;

    // queued command: lo holds the normal (load) or box min (test),
    // hi[0] holds the offset (load), hi holds box max (test)
    typedef struct packed {
        logic                    op;
        logic [INDEX_BITS-1:0]   idx;
        coord_t [AXES-1:0]       lo;
        coord_t [AXES-1:0]       hi;
    } fbc_cmd_t;

    // exact signed product of two coordinates
    function automatic prod_t mul_full(coord_t a, coord_t b);
        prod_t ea;
        prod_t eb;
        ea = prod_t'(a);
        eb = prod_t'(b);
        return ea * eb;
    endfunction

endpackage

/* src/fbc_in_if.sv */
interface fbc_in_if;
    import fbc_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   cmd;
    logic [INDEX_BITS-1:0]  plane_index;
    coord_t                 normal_x;
    coord_t                 normal_y;
    coord_t                 normal_z;
    coord_t                 plane_offset;
    coord_t                 box_min_x;
    coord_t                 box_min_y;
    coord_t                 box_min_z;
    coord_t                 box_max_x;
    coord_t                 box_max_y;
    coord_t                 box_max_z;

    modport source (
        output valid, cmd, plane_index, normal_x, normal_y, normal_z, plane_offset,
               box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
        input  ready
    );

    modport sink (
        input  valid, cmd, plane_index, normal_x, normal_y, normal_z, plane_offset,
               box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
        output ready
    );

endinterface

/* src/fbc_out_if.sv */
interface fbc_out_if;
    import fbc_pkg::*;

    logic       valid;
    logic       ready;
    verdict_t   verdict;

    modport source (
        output valid, verdict,
        input  ready
    );

    modport sink (
        input  valid, verdict,
        output ready
    );

endinterface

/* src/fbc_front.sv */
module fbc_front #(
    parameter int PLANE_COUNT = fbc_pkg::PLANE_COUNT_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    fbc_in_if.sink              item,
    output logic                q_valid,
    output fbc_pkg::fbc_cmd_t   q_data,
    input  logic                pop
);
    import fbc_pkg::*;

    localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    fbc_cmd_t               q_mem [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]    wr_ptr_reg;
    logic [PTR_BITS-1:0]    wr_ptr_next;
    logic [PTR_BITS-1:0]    rd_ptr_reg;
    logic [PTR_BITS-1:0]    rd_ptr_next;
    logic [CNT_BITS-1:0]    count_reg;
    logic [CNT_BITS-1:0]    count_next;
    logic                   accept;
    logic                   keep;
    logic                   push;
    fbc_cmd_t               beat_cmd;

    // accept while the queue has room
    assign item.ready = (count_reg < CNT_BITS'(QUEUE_DEPTH));
    assign accept     = item.valid && item.ready;

    // loads aimed past the table are dropped here, everything else is queued
    assign keep = (item.cmd == CMD_TEST) ||
                  ({1'b0, item.plane_index} < (INDEX_BITS + 1)'(PLANE_COUNT));
    assign push = accept && keep;

    // pack the beat into a queue entry
    always_comb
    begin
        beat_cmd.op    = item.cmd;
        beat_cmd.idx   = item.plane_index;
        if (item.cmd == CMD_LOAD)
        begin
            beat_cmd.lo[0] = item.normal_x;
            beat_cmd.lo[1] = item.normal_y;
            beat_cmd.lo[2] = item.normal_z;
            beat_cmd.hi[0] = item.plane_offset;
            beat_cmd.hi[1] = item.plane_offset;
            beat_cmd.hi[2] = item.plane_offset;
        end
        else
        begin
            beat_cmd.lo[0] = item.box_min_x;
            beat_cmd.lo[1] = item.box_min_y;
            beat_cmd.lo[2] = item.box_min_z;
            beat_cmd.hi[0] = item.box_max_x;
            beat_cmd.hi[1] = item.box_max_y;
            beat_cmd.hi[2] = item.box_max_z;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= beat_cmd;
        end
    end

    assign q_valid = (count_reg != '0);
    assign q_data  = q_mem[rd_ptr_reg];

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // checks
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_BITS'(QUEUE_DEPTH))
        else $error("command queue overfilled");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("pop from empty command queue");

    a_push_visible: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> q_valid)
        else $error("queued command not visible to the back end");

endmodule

/* src/fbc_back.sv */
module fbc_back #(
    parameter int PLANE_COUNT = fbc_pkg::PLANE_COUNT_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  fbc_pkg::fbc_cmd_t   q_data,
    output logic                pop,
    fbc_out_if.source           result
);
    import fbc_pkg::*;

    localparam int TIDX_BITS = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;

    // plane table, undefined until loaded
    coord_t                 nx_mem  [PLANE_COUNT];
    coord_t                 ny_mem  [PLANE_COUNT];
    coord_t                 nz_mem  [PLANE_COUNT];
    coord_t                 off_mem [PLANE_COUNT];

    // issue control
    logic                   run_reg;
    logic                   run_next;
    logic [TIDX_BITS-1:0]   cnt_reg;
    logic [TIDX_BITS-1:0]   cnt_next;
    coord_t [AXES-1:0]      box_lo_reg;
    coord_t [AXES-1:0]      box_hi_reg;
    logic                   is_last;
    logic                   issue;
    logic                   stall;
    logic [TIDX_BITS-1:0]   widx;

    // product stage
    logic                   a_valid_reg;
    logic                   a_first_reg;
    logic                   a_last_reg;
    prod_t                  p_lo_reg [AXES];
    prod_t                  p_hi_reg [AXES];
    lim_t                   lim_reg;

    // compare stage and accumulation
    sum_t                   corner_sum [CORNER_COUNT];
    logic [CORNER_COUNT-1:0] outside;
    logic                   all_out;
    logic                   none_out;
    logic                   culled_reg;
    logic                   clear_reg;
    logic                   culled_now;
    logic                   clear_now;
    logic                   done;

    // output register
    logic                   out_valid_reg;
    verdict_t               verdict_reg;

    // hold everything while a finished verdict has nowhere to go
    assign stall   = a_valid_reg && a_last_reg && out_valid_reg && !result.ready;
    assign is_last = (cnt_reg == TIDX_BITS'(PLANE_COUNT - 1));
    assign issue   = run_reg && !stall;
    assign pop     = q_valid && (!run_reg || is_last) && !stall;
    assign widx    = q_data.idx[TIDX_BITS-1:0];

    // plane table writes
    always_ff @(posedge clk)
    begin
        if (pop && (q_data.op == CMD_LOAD))
        begin
            nx_mem[widx]  <= q_data.lo[0];
            ny_mem[widx]  <= q_data.lo[1];
            nz_mem[widx]  <= q_data.lo[2];
            off_mem[widx] <= q_data.hi[0];
        end
    end

    // box corners latched when a test is taken
    always_ff @(posedge clk)
    begin
        if (pop && (q_data.op == CMD_TEST))
        begin
            box_lo_reg <= q_data.lo;
            box_hi_reg <= q_data.hi;
        end
    end

    // plane sequencer
    always_comb
    begin
        run_next = run_reg;
        cnt_next = cnt_reg;
        if (issue)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (is_last)
            begin
                run_next = 1'b0;
            end
        end
        if (pop)
        begin
            run_next = (q_data.op == CMD_TEST);
            cnt_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
            cnt_reg <= cnt_next;
        end
    end

    // per-plane products: six products cover all eight corners
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            p_lo_reg[0] <= mul_full(nx_mem[cnt_reg], box_lo_reg[0]);
            p_hi_reg[0] <= mul_full(nx_mem[cnt_reg], box_hi_reg[0]);
            p_lo_reg[1] <= mul_full(ny_mem[cnt_reg], box_lo_reg[1]);
            p_hi_reg[1] <= mul_full(ny_mem[cnt_reg], box_hi_reg[1]);
            p_lo_reg[2] <= mul_full(nz_mem[cnt_reg], box_lo_reg[2]);
            p_hi_reg[2] <= mul_full(nz_mem[cnt_reg], box_hi_reg[2]);
            lim_reg     <= $signed({off_mem[cnt_reg], {FRAC_BITS{1'b0}}});
            a_first_reg <= (cnt_reg == '0);
            a_last_reg  <= is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (!stall)
        begin
            a_valid_reg <= run_reg;
        end
    end

    // corner dot products against the scaled offset
    always_comb
    begin
        for (int j = 0; j < CORNER_COUNT; j++)
        begin
            corner_sum[j] = sum_t'(((j & 1) != 0) ? p_hi_reg[0] : p_lo_reg[0])
                          + sum_t'(((j & 2) != 0) ? p_hi_reg[1] : p_lo_reg[1])
                          + sum_t'(((j & 4) != 0) ? p_hi_reg[2] : p_lo_reg[2]);
            outside[j]    = (corner_sum[j] > sum_t'(lim_reg));
        end
    end

    assign all_out    = &outside;
    assign none_out   = ~|outside;
    assign culled_now = (a_first_reg ? 1'b0 : culled_reg) | all_out;
    assign clear_now  = (a_first_reg ? 1'b1 : clear_reg) & none_out;
    assign done       = a_valid_reg && a_last_reg && !stall;

    // running verdict over the planes of one box
    always_ff @(posedge clk)
    begin
        if (a_valid_reg && !stall)
        begin
            culled_reg <= culled_now;
            clear_reg  <= clear_now;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (done)
        begin
            if (culled_now)
            begin
                verdict_reg <= VERDICT_CULLED;
            end
            else if (clear_now)
            begin
                verdict_reg <= VERDICT_VISIBLE;
            end
            else
            begin
                verdict_reg <= VERDICT_PARTIAL;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.verdict = verdict_reg;

    // checks
    a_no_pop_mid_box: assert property (@(posedge clk) disable iff (!rst_n)
        (run_reg && !is_last) |-> !pop)
        else $error("command taken while planes of a box remain");

    a_test_starts_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && (q_data.op == CMD_TEST)) |=> (run_reg && (cnt_reg == '0)))
        else $error("box test did not start at the first plane");

    a_box_boundary: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (!a_valid_reg || a_first_reg))
        else $error("plane after a box's last plane is not a first plane");

    a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (verdict_reg != 2'd3))
        else $error("verdict register holds an unused code");

endmodule

/* src/frustum_box_cull_classifier_unit.sv */
// channel   dir   beat carries
// item      in    cmd, plane_index, plane normal and offset, box min and max
// result    out   verdict for each box test beat
//
// a plane load is written to the plane table as it leaves the two-entry queue;
// a box test runs one plane per cycle, unless a stalled result holds it, through
// six shared multipliers feeding eight corner sums; a waiting command leaves the
// queue as a box's last plane issues; the compare stage feeds the result register
// rst_n clears control only; the plane table is undefined until loaded
// a stalled result holds the back end; the queue lets the front accept until full
module frustum_box_cull_classifier_unit #(
    parameter int PLANE_COUNT = fbc_pkg::PLANE_COUNT_DEF
) (
    input  logic    clk,
    input  logic    rst_n,
    fbc_in_if.sink  item,
    fbc_out_if.source result
);
    import fbc_pkg::*;

    logic       q_valid;
    fbc_cmd_t   q_data;
    logic       pop;

    // accept, filter and queue commands
    fbc_front #(
        .PLANE_COUNT (PLANE_COUNT)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .q_valid (q_valid),
        .q_data  (q_data),
        .pop     (pop)
    );

    // plane table, per-plane test and result register
    fbc_back #(
        .PLANE_COUNT (PLANE_COUNT)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_data  (q_data),
        .pop     (pop),
        .result  (result)
    );

endmodule
